FILE: hw/rtl/multi_token_bucket_limiter_assert.svh
// Assertion macros shared by the token bucket limiter RTL.
// Every use assumes a clock named clk and an active-low reset named rst_n.
`ifndef MULTI_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define MULTI_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MTBL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, checked outside reset
`define MTBL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

FILE: hw/rtl/mtbl_pkg.sv
// Types and constants for the multi token bucket limiter.
// No dependencies; used by mtbl_cell and multi_token_bucket_limiter.
`timescale 1ns / 1ps
`default_nettype none

package mtbl_pkg;

    // Fixed field widths
    localparam int OP_W       = 3;
    localparam int BUCKET_W   = 4;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int GRANT_W    = 16;
    localparam int S_TUSER_W  = 3;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;

    // Parameter defaults
    localparam int DEF_NUM_BUCKETS = 16;
    localparam int DEF_COUNT_BITS  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_ACQUIRE = 3'd2,
        OP_RELEASE = 3'd3,
        OP_DESTROY = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_SLOT = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // Request as it travels down the cell chain
    typedef struct packed {
        op_t                 op;
        logic [BUCKET_W-1:0] bucket;
        logic [AMOUNT_W-1:0] amount;
        logic [AMOUNT_W-1:0] rate;
        logic [AMOUNT_W-1:0] burst_limit;
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [GRANT_W-1:0]  granted;
        logic                hit;      // some cell took or matched the request
    } req_t;

endpackage : mtbl_pkg

`default_nettype wire

FILE: hw/rtl/multi_token_bucket_limiter.sv
// Throughput: one request per cycle unless a full result register stalls the chain.
// Each request visits every bucket cell register in order, then the result register.
// Tick updates each cell as the tick request passes it, so requests never overtake.
// Reset (rst_n, async, active low) frees all buckets and empties the chain at once.
// Top level of the multi token bucket limiter; instantiates mtbl_cell.
// Depends on mtbl_pkg and multi_token_bucket_limiter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_token_bucket_limiter_assert.svh"

module multi_token_bucket_limiter
    import mtbl_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // bucket[3:0], amount[19:4], rate[35:20], burst_limit[51:36], zero pad[55:52]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // operation[2:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[1:0], slot[5:2], granted[21:6], zero pad[23:22]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int PAD_W = M_TDATA_W - STATUS_W - SLOT_W - GRANT_W;

    logic    adv;
    logic    stage_valid [NUM_BUCKETS+1];
    req_t    stage_req   [NUM_BUCKETS+1];
    req_t    tail;
    status_t fin_status;
    logic [SLOT_W-1:0]   fin_slot;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [GRANT_W-1:0]  granted_reg;

    // Move the whole chain when the result register can take a value
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Unpack the incoming request
    always_comb
    begin
        stage_req[0]             = '0;
        stage_req[0].op          = op_t'(s_tuser[OP_W-1:0]);
        stage_req[0].bucket      = s_tdata[BUCKET_W-1:0];
        stage_req[0].amount      = s_tdata[BUCKET_W +: AMOUNT_W];
        stage_req[0].rate        = s_tdata[BUCKET_W+AMOUNT_W +: AMOUNT_W];
        stage_req[0].burst_limit = s_tdata[BUCKET_W+2*AMOUNT_W +: AMOUNT_W];
        stage_req[0].status      = ST_OK;
        stage_req[0].slot        = s_tdata[BUCKET_W-1:0];
        stage_req[0].granted     = '0;
        stage_req[0].hit         = 1'b0;
    end
    assign stage_valid[0] = s_tvalid;

    // Chain of bucket cells
    for (genvar i = 0; i < NUM_BUCKETS; i++)
    begin : g_cell
        mtbl_cell #(
            .CELL_IDX   (i),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (stage_valid[i]),
            .in_req    (stage_req[i]),
            .out_valid (stage_valid[i+1]),
            .out_req   (stage_req[i+1])
        );
    end

    assign tail = stage_req[NUM_BUCKETS];

    // Resolve the final status once every cell has seen the request
    always_comb
    begin
        fin_status = tail.status;
        fin_slot   = tail.slot;
        case (tail.op)
            OP_TICK:
            begin
                fin_status = ST_OK;
                fin_slot   = '0;
            end
            OP_CREATE:
            begin
                if (!tail.hit)
                begin
                    fin_status = ST_NO_SLOT;
                    fin_slot   = '0;
                end
            end
            OP_ACQUIRE, OP_RELEASE, OP_DESTROY:
            begin
                if (!tail.hit)
                begin
                    fin_status = ST_INVALID;
                end
            end
            default:
            begin
                fin_status = ST_OK;
            end
        endcase
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= stage_valid[NUM_BUCKETS];
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg  <= fin_status;
            slot_reg    <= fin_slot;
            granted_reg <= tail.granted;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, granted_reg, slot_reg, status_reg};

    // An empty result register never blocks the input
    `MTBL_ASSERT_IMP(a_ready_when_empty, !m_valid_reg, s_tready)
    // Tokens are granted only with an ok status
    `MTBL_ASSERT_IMP(a_grant_ok, m_valid_reg && granted_reg != '0, status_reg == ST_OK)
    // A failed create reports slot zero
    `MTBL_ASSERT_IMP(a_noslot_zero, m_valid_reg && status_reg == ST_NO_SLOT, slot_reg == '0)

endmodule : multi_token_bucket_limiter

`default_nettype wire

FILE: hw/rtl/mtbl_cell.sv
// One bucket cell of the limiter chain: holds one bucket and applies each passing request.
// Depends on mtbl_pkg and multi_token_bucket_limiter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_token_bucket_limiter_assert.svh"

module mtbl_cell
    import mtbl_pkg::*;
#(
    parameter int CELL_IDX   = 0,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic in_valid,
    input  wire req_t in_req,
    output logic      out_valid,
    output req_t      out_req
);

    localparam int SW = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
    localparam bit ADDRESSABLE = (CELL_IDX < (1 << SLOT_W));
    localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(CELL_IDX);

    logic                  valid_reg, valid_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] rate_reg,  rate_next;
    logic [COUNT_BITS-1:0] limit_reg, limit_next;
    logic                  out_valid_reg;
    req_t                  out_req_reg, out_req_next;

    logic [SW-1:0] cnt_ext, cap_ext, amt_ext, tick_sum, rel_sum, grant_w;
    logic          hit_here;
    logic          take_all;

    // Widen operands for saturating adds and grant compare
    assign cnt_ext  = SW'(count_reg);
    assign cap_ext  = SW'(limit_reg);
    assign amt_ext  = SW'(in_req.amount);
    assign tick_sum = cnt_ext + SW'(rate_reg);
    assign rel_sum  = cnt_ext + amt_ext;
    assign take_all = amt_ext > cnt_ext;
    assign grant_w  = take_all ? cnt_ext : amt_ext;
    assign hit_here = ADDRESSABLE && valid_reg && (in_req.bucket == CELL_SLOT);

    // Apply the request to this bucket
    always_comb
    begin
        valid_next   = valid_reg;
        count_next   = count_reg;
        rate_next    = rate_reg;
        limit_next   = limit_reg;
        out_req_next = in_req;
        case (in_req.op)
            OP_TICK:
            begin
                if (valid_reg)
                begin
                    count_next = (tick_sum >= cap_ext) ? limit_reg : COUNT_BITS'(tick_sum);
                end
            end
            OP_CREATE:
            begin
                if (!in_req.hit && !valid_reg)
                begin
                    valid_next        = 1'b1;
                    count_next        = '0;
                    rate_next         = COUNT_BITS'(in_req.rate);
                    limit_next        = COUNT_BITS'(in_req.burst_limit);
                    out_req_next.hit  = 1'b1;
                    out_req_next.slot = CELL_SLOT;
                end
            end
            OP_ACQUIRE:
            begin
                if (hit_here)
                begin
                    out_req_next.hit = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_req_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        out_req_next.granted = GRANT_W'(grant_w);
                        count_next           = COUNT_BITS'(cnt_ext - grant_w);
                    end
                end
            end
            OP_RELEASE:
            begin
                if (hit_here)
                begin
                    out_req_next.hit = 1'b1;
                    count_next = (rel_sum >= cap_ext) ? limit_reg : COUNT_BITS'(rel_sum);
                end
            end
            OP_DESTROY:
            begin
                if (hit_here)
                begin
                    out_req_next.hit = 1'b1;
                    valid_next       = 1'b0;
                end
            end
            default:
            begin
                out_req_next = in_req;
            end
        endcase
    end

    // Hold control state; advance the chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    // Bucket payload and passed-on request
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_req_reg <= out_req_next;
            if (in_valid)
            begin
                count_reg <= count_next;
                rate_reg  <= rate_next;
                limit_reg <= limit_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

    // A live bucket never holds more than its burst limit
    `MTBL_ASSERT_IMP(a_count_le_limit, valid_reg, count_reg <= limit_reg)
    // A free cell seeing an unclaimed create becomes live
    `MTBL_ASSERT_NXT(a_create_claims,
        adv && in_valid && in_req.op == OP_CREATE && !in_req.hit && !valid_reg,
        valid_reg && out_req_reg.hit && out_req_reg.slot == CELL_SLOT)
    // Once a request is taken it stays taken down the chain
    `MTBL_ASSERT_NXT(a_hit_kept, adv && in_valid && in_req.hit, out_valid_reg && out_req_reg.hit)

endmodule : mtbl_cell

`default_nettype wire

FILE: tb/sv/mtbl_bucket_checker.sv
`timescale 1ns / 1ps
// Bucket table checker for the multi token bucket limiter: watches both streams,
// keeps its own copy of the bucket table and compares every result it predicts.
// Depends on mtbl_pkg for field widths and the operation and status codes.

module mtbl_bucket_checker
    import mtbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // bucket[3:0], amount[19:4], rate[35:20], burst_limit[51:36], zero pad[55:52]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // status[1:0], slot[5:2], granted[21:6], zero pad[23:22]
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    output int                         errors,
    output int                         pending,
    output int                         checked,
    output logic [DEF_NUM_BUCKETS-1:0] live_mask
);

    localparam int NB = DEF_NUM_BUCKETS;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [GRANT_W-1:0]  granted;
    } reply_t;

    // Predicted bucket table
    logic [NB-1:0]       in_use;
    logic [AMOUNT_W-1:0] tokens [NB];
    logic [AMOUNT_W-1:0] refill [NB];
    logic [AMOUNT_W-1:0] cap    [NB];

    reply_t replies_due [$];

    // Add with saturation at the bucket's burst limit
    function automatic logic [AMOUNT_W-1:0] sat_sum(input logic [AMOUNT_W-1:0] a,
                                                    input logic [AMOUNT_W-1:0] b,
                                                    input logic [AMOUNT_W-1:0] lim);
        logic [AMOUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, lim}) ? lim : s[AMOUNT_W-1:0];
    endfunction

    // Print one line per mismatch and count it
    task automatic report(input string what, input logic [31:0] want, input logic [31:0] seen);
        errors++;
        $display("%0t ns mismatch: %s expected %0h got %0h", $time, what, want, seen);
    endtask

    // Update the table for one accepted request and work out its reply
    task automatic apply_bucket_request(input logic [S_TUSER_W-1:0] opcode,
                                        input logic [S_TDATA_W-1:0] data,
                                        output reply_t ans);
        logic [BUCKET_W-1:0] b;
        logic [AMOUNT_W-1:0] amt;
        logic [AMOUNT_W-1:0] rt;
        logic [AMOUNT_W-1:0] bl;
        bit                  found;
        b   = data[BUCKET_W-1:0];
        amt = data[BUCKET_W +: AMOUNT_W];
        rt  = data[BUCKET_W + AMOUNT_W +: AMOUNT_W];
        bl  = data[BUCKET_W + 2*AMOUNT_W +: AMOUNT_W];
        ans.status  = ST_OK;
        ans.slot    = b;
        ans.granted = '0;
        found       = 1'b0;
        case (opcode)
            OP_TICK:
            begin
                ans.slot = '0;
                for (int i = 0; i < NB; i++)
                    if (in_use[i])
                        tokens[i] = sat_sum(tokens[i], refill[i], cap[i]);
            end
            OP_CREATE:
            begin
                ans.slot   = '0;
                ans.status = ST_NO_SLOT;
                // take the lowest free slot, empty
                for (int i = 0; i < NB; i++)
                begin
                    if (!found && !in_use[i])
                    begin
                        found      = 1'b1;
                        in_use[i]  = 1'b1;
                        tokens[i]  = '0;
                        refill[i]  = rt;
                        cap[i]     = bl;
                        ans.slot   = SLOT_W'(i);
                        ans.status = ST_OK;
                    end
                end
            end
            OP_ACQUIRE:
            begin
                if (!in_use[b])
                    ans.status = ST_INVALID;
                else if (tokens[b] == '0)
                    ans.status = ST_EMPTY;
                else if (amt > tokens[b])
                begin
                    ans.granted = tokens[b];
                    tokens[b]   = '0;
                end
                else
                begin
                    ans.granted = amt;
                    tokens[b]   = tokens[b] - amt;
                end
            end
            OP_RELEASE:
            begin
                if (!in_use[b])
                    ans.status = ST_INVALID;
                else
                    tokens[b] = sat_sum(tokens[b], amt, cap[b]);
            end
            OP_DESTROY:
            begin
                if (!in_use[b])
                    ans.status = ST_INVALID;
                else
                    in_use[b] = 1'b0;
            end
            default:
            begin
                // reserved codes leave the table alone
            end
        endcase
    endtask

    // Match results against the oldest reply, then queue the new request's reply
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t fresh;
        if (!rst_n)
        begin
            in_use = '0;
            replies_due.delete();
            errors    = 0;
            checked   = 0;
            pending   <= 0;
            live_mask <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (replies_due.size() == 0)
                    report("result with no request waiting", 32'd0, 32'(m_tdata));
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                        report("status", 32'(want.status), 32'(m_tdata[STATUS_W-1:0]));
                    if (m_tdata[STATUS_W +: SLOT_W] !== want.slot)
                        report("slot", 32'(want.slot), 32'(m_tdata[STATUS_W +: SLOT_W]));
                    if (m_tdata[STATUS_W + SLOT_W +: GRANT_W] !== want.granted)
                        report("granted", 32'(want.granted),
                               32'(m_tdata[STATUS_W + SLOT_W +: GRANT_W]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_bucket_request(s_tuser, s_tdata, fresh);
                replies_due.push_back(fresh);
            end
            pending   <= replies_due.size();
            live_mask <= in_use;
        end
    end

endmodule

FILE: tb/sv/tb_multi_token_bucket_limiter.sv
`timescale 1ns / 1ps
// Testbench top for the multi token bucket limiter: drives directed and random
// requests with random gaps and stalls, and gives the verdict from mtbl_bucket_checker.
// Depends on mtbl_pkg, multi_token_bucket_limiter and mtbl_bucket_checker.

module tb_multi_token_bucket_limiter;
    import mtbl_pkg::*;

    // Operation codes the block does not define
    localparam logic [S_TUSER_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [S_TUSER_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [S_TUSER_W-1:0] OP_RSVD_C = 3'd7;
    localparam int PAD_W  = S_TDATA_W - (BUCKET_W + 3*AMOUNT_W);
    localparam int PHASES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    wire logic             s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    wire logic             m_tvalid;
    logic                  m_tready;
    wire logic [M_TDATA_W-1:0] m_tdata;

    int                        errors;
    int                        pending;
    int                        checked;
    logic [DEF_NUM_BUCKETS-1:0] live_mask;

    bit quiet;
    int sent;
    int op_count [8];

    multi_token_bucket_limiter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mtbl_bucket_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .live_mask (live_mask)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Token-ish values: mostly small, some full range, the extremes now and then
    function automatic logic [AMOUNT_W-1:0] rand_word();
        int r;
        logic [AMOUNT_W-1:0] v;
        r = $urandom_range(0, 19);
        if (r == 0)
            v = '0;
        else if (r == 1)
            v = '1;
        else if (r < 10)
            v = AMOUNT_W'($urandom_range(0, 15));
        else if (r < 15)
            v = AMOUNT_W'($urandom_range(0, 255));
        else
            v = AMOUNT_W'($urandom_range(0, 65535));
        return v;
    endfunction

    // Mostly a live bucket, otherwise any descriptor
    function automatic logic [BUCKET_W-1:0] pick_bucket();
        int start;
        int idx;
        bit hit;
        start = $urandom_range(0, DEF_NUM_BUCKETS-1);
        idx   = start;
        hit   = 1'b0;
        if (live_mask != '0 && $urandom_range(0, 9) < 8)
        begin
            for (int k = 0; k < DEF_NUM_BUCKETS; k++)
            begin
                if (!hit && live_mask[(start + k) % DEF_NUM_BUCKETS])
                begin
                    hit = 1'b1;
                    idx = (start + k) % DEF_NUM_BUCKETS;
                end
            end
        end
        return BUCKET_W'(idx);
    endfunction

    // Operation mix per phase: fill the table, mixed traffic, drain and free
    function automatic logic [S_TUSER_W-1:0] pick_op(input int mode);
        int r;
        int c;
        int t;
        int a;
        int l;
        logic [S_TUSER_W-1:0] op;
        case (mode)
            0:       begin c = 50; t = 15; a = 15; l = 10; end
            1:       begin c = 15; t = 20; a = 30; l = 20; end
            default: begin c = 6;  t = 14; a = 40; l = 15; end
        endcase
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            op = S_TUSER_W'($urandom_range(0, 7));
        else if (r < c)
            op = OP_CREATE;
        else if (r < c + t)
            op = OP_TICK;
        else if (r < c + t + a)
            op = OP_ACQUIRE;
        else if (r < c + t + a + l)
            op = OP_RELEASE;
        else
            op = OP_DESTROY;
        return op;
    endfunction

    // Send one request after a random gap (none while quiet); returns at the accepting edge
    task automatic send_req(input logic [S_TUSER_W-1:0] opcode,
                            input logic [BUCKET_W-1:0]  bkt,
                            input logic [AMOUNT_W-1:0]  amt,
                            input logic [AMOUNT_W-1:0]  rt,
                            input logic [AMOUNT_W-1:0]  bl);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opcode;
        s_tdata  <= {{PAD_W{1'b0}}, bl, rt, amt, bkt};
        do
            @(posedge clk);
        while (!s_tready);
        op_count[opcode]++;
        sent++;
    endtask

    // Result side: after each accepted result, drop m_tready for a random stall (none while quiet)
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int n;
        int known;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        rst_n    = 1'b0;
        quiet    = 1'b0;
        sent     = 0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, create, empty and saturating buckets, reserved codes
        send_req(OP_TICK,    4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_ACQUIRE, 4'd15, 16'hFFFF, 16'h0000, 16'h0000);
        send_req(OP_RELEASE, 4'd9,  16'h0001, 16'h0000, 16'h0000);
        send_req(OP_DESTROY, 4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_CREATE,  4'd7,  16'h0000, 16'hFFFF, 16'hFFFF);
        send_req(OP_CREATE,  4'd0,  16'h0000, 16'h0003, 16'h0005);
        send_req(OP_CREATE,  4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_ACQUIRE, 4'd0,  16'h0001, 16'h0000, 16'h0000);
        send_req(OP_TICK,    4'd3,  16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(OP_ACQUIRE, 4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_ACQUIRE, 4'd0,  16'hFFFF, 16'h0000, 16'h0000);
        send_req(OP_TICK,    4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_TICK,    4'd0,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_ACQUIRE, 4'd1,  16'h0002, 16'h0000, 16'h0000);
        send_req(OP_RELEASE, 4'd1,  16'hFFFF, 16'h0000, 16'h0000);
        send_req(OP_RELEASE, 4'd0,  16'h1234, 16'h0000, 16'h0000);
        send_req(OP_ACQUIRE, 4'd2,  16'h0007, 16'h0000, 16'h0000);
        send_req(OP_RSVD_A,  4'd10, 16'h0000, 16'h0000, 16'h0000);
        send_req(OP_RSVD_B,  4'd5,  16'hFFFF, 16'h0000, 16'h0000);
        send_req(OP_RSVD_C,  4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(OP_DESTROY, 4'd1,  16'h0000, 16'h0000, 16'h0000);
        send_req(OP_CREATE,  4'd0,  16'h0000, 16'h8000, 16'h7FFF);
        send_req(OP_ACQUIRE, 4'd1,  16'h0000, 16'h0000, 16'h0000);

        // Random phases; hold the sender at each boundary until all results are in
        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiet = (phase == 2) || (phase == 5);
            repeat (100)
                send_req(pick_op(phase % 3), pick_bucket(), rand_word(), rand_word(),
                         rand_word());
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (pending != 0);
        end
        quiet = 1'b0;

        // Drain, then watch a while longer for stray results
        n = 0;
        while (pending != 0 && n < 2000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4 * DEF_NUM_BUCKETS) @(posedge clk);

        known = op_count[OP_TICK] + op_count[OP_CREATE] + op_count[OP_ACQUIRE]
              + op_count[OP_RELEASE] + op_count[OP_DESTROY];
        $write("covered %0d requests: %0d tick, %0d create, %0d acquire, ",
               sent, op_count[OP_TICK], op_count[OP_CREATE], op_count[OP_ACQUIRE]);
        $display("%0d release, %0d destroy, %0d reserved",
                 op_count[OP_RELEASE], op_count[OP_DESTROY], sent - known);
        $display("%0d results compared, %0d mismatches, %0d results never arrived",
                 checked, errors, pending);
        if (errors == 0 && pending == 0)
            $display("tb_multi_token_bucket_limiter: PASS");
        else
            $display("tb_multi_token_bucket_limiter: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("tb_multi_token_bucket_limiter: FAIL");
        $finish;
    end

endmodule
